>>> rtl/bccng_pkg.sv
// ----------------------------------------------------------------------------
// bccng_pkg
// shared widths, codes, candidate masks and queue types for the bcc
// lattice neighbor generator
// ----------------------------------------------------------------------------
`default_nettype none

package bccng_pkg;

  // coordinate width of one lattice axis
  localparam int CoordBits = 10;
  // box size after clamping: 0 .. 2^CoordBits
  localparam int SizeW     = CoordBits + 1;
  // sx * sy
  localparam int SxyW      = 2 * SizeW;
  // product ny * sx
  localparam int PyW       = CoordBits + SizeW;
  localparam int IdxW      = 30;

  // configuration register widths
  localparam int BcxW      = 10;
  localparam int CfgW      = 11;
  localparam int CfgIdxW   = 2;
  localparam int CmpW      = (CfgW > SizeW) ? CfgW : SizeW;

  localparam int NumCand   = 8;
  localparam int CandIdxW  = 3;

  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;
  localparam int QCntW     = QPtrW + 1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegBoxCellsX = 2'd0,
    RegBoxSitesY = 2'd1,
    RegBoxSitesZ = 2'd2
  } cfg_reg_t;

  // query selector
  localparam logic FuncFirst  = 1'b0;
  localparam logic FuncSecond = 1'b1;

  // second neighbor order
  localparam logic [CandIdxW-1:0] SecXMinus = 3'd0;
  localparam logic [CandIdxW-1:0] SecYMinus = 3'd1;
  localparam logic [CandIdxW-1:0] SecZMinus = 3'd2;
  localparam logic [CandIdxW-1:0] SecZPlus  = 3'd3;
  localparam logic [CandIdxW-1:0] SecYPlus  = 3'd4;
  localparam logic [CandIdxW-1:0] SecXPlus  = 3'd5;

  // first neighbor candidate groups (candidate i is bit i)
  localparam logic [NumCand-1:0] MaskXMinus = 8'h0F;
  localparam logic [NumCand-1:0] MaskXPlus  = 8'hF0;
  localparam logic [NumCand-1:0] MaskDyHi   = 8'hCC;
  localparam logic [NumCand-1:0] MaskDyLo   = 8'h33;
  localparam logic [NumCand-1:0] MaskDzHi   = 8'hAA;
  localparam logic [NumCand-1:0] MaskDzLo   = 8'h55;

  // one classified query: an empty mask means a none_found result
  typedef struct packed {
    logic                 func;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [NumCand-1:0]   mask;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/bccng_front.sv
// ----------------------------------------------------------------------------
// bccng_front
// takes queries and classifies them into a candidate mask per query
// ----------------------------------------------------------------------------
`default_nettype none

module bccng_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [bccng_pkg::CoordBits-1:0] in_site_x,
  input  wire logic [bccng_pkg::CoordBits-1:0] in_site_y,
  input  wire logic [bccng_pkg::CoordBits-1:0] in_site_z,
  input  wire logic [bccng_pkg::SizeW-1:0]     sx,
  input  wire logic [bccng_pkg::SizeW-1:0]     sy,
  input  wire logic [bccng_pkg::SizeW-1:0]     sz,
  input  wire bccng_pkg::q_status_t            q_status,
  output logic                                push,
  output bccng_pkg::entry_t                   push_entry
);
  import bccng_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  entry_t             entry_r;
  logic               accept;
  logic [SizeW-1:0]   xe, ye, ze;
  logic               in_box;
  logic               xm1, xm2, xp1, xp2, ym1, yp1, zm1, zp1;
  logic [NumCand-1:0] mx, my, mz;
  logic [NumCand-1:0] first_mask, second_mask, mask;

  assign in_stall   = valid_r && q_status.full;
  assign accept     = in_valid && !in_stall;
  assign push       = valid_r && !q_status.full;
  assign push_entry = entry_r;

  assign xe = SizeW'(in_site_x);
  assign ye = SizeW'(in_site_y);
  assign ze = SizeW'(in_site_z);

  assign in_box = (xe < sx) && (ye < sy) && (ze < sz);

  // bound tests per direction
  assign xm1 = (in_site_x != '0);
  assign xm2 = (in_site_x[CoordBits-1:1] != '0);
  assign xp1 = ((xe + SizeW'(1)) < sx);
  assign xp2 = ((xe + SizeW'(2)) < sx);
  assign ym1 = (in_site_y != '0);
  assign yp1 = ((ye + SizeW'(1)) < sy);
  assign zm1 = (in_site_z != '0);
  assign zp1 = ((ze + SizeW'(1)) < sz);

  always_comb begin
    mx = (xm1 ? MaskXMinus : '0) | (xp1 ? MaskXPlus : '0);
    if (in_site_x[0]) begin
      // odd x: offsets 0 or +1
      my = MaskDyLo | (yp1 ? MaskDyHi : '0);
      mz = MaskDzLo | (zp1 ? MaskDzHi : '0);
    end else begin
      // even x: offsets -1 or 0
      my = MaskDyHi | (ym1 ? MaskDyLo : '0);
      mz = MaskDzHi | (zm1 ? MaskDzLo : '0);
    end
    first_mask = mx & my & mz;

    second_mask            = '0;
    second_mask[SecXMinus] = xm2;
    second_mask[SecYMinus] = ym1;
    second_mask[SecZMinus] = zm1;
    second_mask[SecZPlus]  = zp1;
    second_mask[SecYPlus]  = yp1;
    second_mask[SecXPlus]  = xp2;

    if (!in_box) begin
      mask = '0;
    end else if (in_func == FuncSecond) begin
      mask = second_mask;
    end else begin
      mask = first_mask;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r.func <= in_func;
      entry_r.x    <= in_site_x;
      entry_r.y    <= in_site_y;
      entry_r.z    <= in_site_z;
      entry_r.mask <= mask;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bccng_fifo.sv
// ----------------------------------------------------------------------------
// bccng_fifo
// short queue of classified queries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bccng_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bccng_pkg::entry_t push_entry,
  input  wire logic              pop,
  output bccng_pkg::entry_t      head,
  output bccng_pkg::q_status_t   status
);
  import bccng_pkg::*;

  entry_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == QCntW'(QDepth));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bccng_back.sv
// ----------------------------------------------------------------------------
// bccng_back
// walks the candidate mask of the head query, one neighbor per cycle while the
// output is not stalled, and computes its coordinates and linear index in a three-stage pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module bccng_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bccng_pkg::entry_t               head,
  input  wire bccng_pkg::q_status_t            q_status,
  output logic                                 pop,
  input  wire logic [bccng_pkg::SizeW-1:0]     sx,
  input  wire logic [bccng_pkg::SxyW-1:0]      sxy,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bccng_pkg::CoordBits-1:0]      out_nbr_x,
  output logic [bccng_pkg::CoordBits-1:0]      out_nbr_y,
  output logic [bccng_pkg::CoordBits-1:0]      out_nbr_z,
  output logic [bccng_pkg::IdxW-1:0]           out_site_index,
  output logic                                 out_none_found,
  output logic                                 out_last
);
  import bccng_pkg::*;

  logic                 en;
  logic                 emit;
  logic                 started_r, started_nxt;
  logic [NumCand-1:0]   rem_r, rem_nxt;
  logic [NumCand-1:0]   cur, low_bit;
  logic [CandIdxW-1:0]  sel;
  logic [CoordBits-1:0] nx, ny, nz;

  // stage 1: neighbor coordinates
  logic                 s1_valid_r, s1_none_r, s1_last_r;
  logic [CoordBits-1:0] s1_x_r, s1_y_r, s1_z_r;
  // stage 2: products
  logic                 s2_valid_r, s2_none_r, s2_last_r;
  logic [CoordBits-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic [PyW-1:0]       s2_py_r;
  logic [IdxW-1:0]      s2_pz_r;
  // stage 3: output register
  logic                 s3_valid_r, s3_none_r, s3_last_r;
  logic [CoordBits-1:0] s3_x_r, s3_y_r, s3_z_r;
  logic [IdxW-1:0]      s3_idx_r;

  // the whole pipe moves while the output register can take a new result
  assign en   = !s3_valid_r || !out_stall;
  assign emit = en && !q_status.empty;

  assign cur     = started_r ? rem_r : head.mask;
  assign low_bit = cur & (~cur + NumCand'(1));
  assign rem_nxt = cur & ~low_bit;
  assign pop     = emit && (rem_nxt == '0);

  always_comb begin
    sel = '0;
    for (int i = NumCand - 1; i >= 0; i--) begin
      if (low_bit[i]) begin
        sel = CandIdxW'(i);
      end
    end
  end

  always_comb begin
    nx = head.x;
    ny = head.y;
    nz = head.z;
    if (head.func == FuncFirst) begin
      nx = sel[2] ? head.x + CoordBits'(1) : head.x - CoordBits'(1);
      if (head.x[0]) begin
        ny = head.y + CoordBits'(sel[1]);
        nz = head.z + CoordBits'(sel[0]);
      end else begin
        ny = head.y - CoordBits'(!sel[1]);
        nz = head.z - CoordBits'(!sel[0]);
      end
    end else begin
      case (sel)
        SecXMinus: nx = head.x - CoordBits'(2);
        SecYMinus: ny = head.y - CoordBits'(1);
        SecZMinus: nz = head.z - CoordBits'(1);
        SecZPlus:  nz = head.z + CoordBits'(1);
        SecYPlus:  ny = head.y + CoordBits'(1);
        SecXPlus:  nx = head.x + CoordBits'(2);
        default:   nx = head.x;
      endcase
    end
  end

  always_comb begin
    started_nxt = started_r;
    if (emit) begin
      started_nxt = (rem_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      if (en) begin
        s1_valid_r <= emit;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rem_r <= rem_nxt;
    end
    if (en) begin
      s1_none_r <= (cur == '0);
      s1_last_r <= (rem_nxt == '0);
      s1_x_r    <= nx;
      s1_y_r    <= ny;
      s1_z_r    <= nz;

      s2_none_r <= s1_none_r;
      s2_last_r <= s1_last_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_z_r    <= s1_z_r;
      s2_py_r   <= PyW'(s1_y_r) * PyW'(sx);
      s2_pz_r   <= IdxW'(s1_z_r) * IdxW'(sxy);

      s3_none_r <= s2_none_r;
      s3_last_r <= s2_last_r;
      s3_x_r    <= s2_none_r ? '0 : s2_x_r;
      s3_y_r    <= s2_none_r ? '0 : s2_y_r;
      s3_z_r    <= s2_none_r ? '0 : s2_z_r;
      s3_idx_r  <= s2_none_r ? '0 : IdxW'(s2_x_r) + IdxW'(s2_py_r) + s2_pz_r;
    end
  end

  assign out_valid      = s3_valid_r;
  assign out_nbr_x      = s3_x_r;
  assign out_nbr_y      = s3_y_r;
  assign out_nbr_z      = s3_z_r;
  assign out_site_index = s3_idx_r;
  assign out_none_found = s3_none_r;
  assign out_last       = s3_last_r;

endmodule

`default_nettype wire

>>> rtl/bcc_lattice_neighbor_generator.sv
// ----------------------------------------------------------------------------
// bcc_lattice_neighbor_generator
// neighbor site generator for a body-centered cubic lattice box
// ----------------------------------------------------------------------------
// Each query names a site (x, y, z) and a selector: func 0 asks for the eight
// first neighbors, func 1 for the six second neighbors in the order -x, -y,
// -z, +z, +y, +x. Every neighbor inside the box (sx = 2*box_cells_x, sy, sz,
// each clamped to 2^CoordBits, no periodic wrap) comes out as one transfer
// with its coordinates and linear index x + y*sx + z*sx*sy; the final transfer
// of a query has last set. A query outside the box, or one with no neighbor
// in it, gives a single transfer with none_found and last set and all other
// fields zero. A query gives one result transfer per result, 1 to 8; the back
// end emits one neighbor per cycle while the output is not stalled, and
// queries follow each other with no gap. The front registers each classified
// query and a four-entry queue decouples it from the back end, so input
// transfers keep flowing while results are stalled until the queue fills.
// Writes to the box size registers must happen while the block is idle.
`default_nettype none

module bcc_lattice_neighbor_generator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [bccng_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [bccng_pkg::CfgW-1:0]       cfg_wdata,
  // query channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [bccng_pkg::CoordBits-1:0]  in_site_x,
  input  wire logic [bccng_pkg::CoordBits-1:0]  in_site_y,
  input  wire logic [bccng_pkg::CoordBits-1:0]  in_site_z,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bccng_pkg::CoordBits-1:0]       out_nbr_x,
  output logic [bccng_pkg::CoordBits-1:0]       out_nbr_y,
  output logic [bccng_pkg::CoordBits-1:0]       out_nbr_z,
  output logic [bccng_pkg::IdxW-1:0]            out_site_index,
  output logic                                  out_none_found,
  output logic                                  out_last
);
  import bccng_pkg::*;

  localparam logic [CmpW-1:0] SizeLim = CmpW'(1) << CoordBits;

  // clamped box sizes, kept ready for the datapath
  logic [SizeW-1:0] sx_r, sy_r, sz_r;
  logic [SizeW-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic [SxyW-1:0]  sxy_r;
  logic [CmpW-1:0]  sx_raw, sy_raw, sz_raw;

  logic      push, pop;
  entry_t    push_entry, head;
  q_status_t q_status;

  // sx is twice the cell count; every size saturates at 2^CoordBits
  assign sx_raw = CmpW'({cfg_wdata[BcxW-1:0], 1'b0});
  assign sy_raw = CmpW'(cfg_wdata);
  assign sz_raw = CmpW'(cfg_wdata);

  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sz_nxt = sz_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        RegBoxCellsX: sx_nxt = SizeW'((sx_raw > SizeLim) ? SizeLim : sx_raw);
        RegBoxSitesY: sy_nxt = SizeW'((sy_raw > SizeLim) ? SizeLim : sy_raw);
        RegBoxSitesZ: sz_nxt = SizeW'((sz_raw > SizeLim) ? SizeLim : sz_raw);
        default:      sx_nxt = sx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r  <= SizeW'(2);
      sy_r  <= SizeW'(1);
      sz_r  <= SizeW'(1);
      sxy_r <= SxyW'(2);
    end else begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sz_r  <= sz_nxt;
      // plane size follows the registers in the next cycle, well before use
      sxy_r <= SxyW'(sx_r) * SxyW'(sy_r);
    end
  end

  // front: take and classify queries
  bccng_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_site_x  (in_site_x),
    .in_site_y  (in_site_y),
    .in_site_z  (in_site_z),
    .sx         (sx_r),
    .sy         (sy_r),
    .sz         (sz_r),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue of classified queries
  bccng_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // back: one neighbor per cycle while the output is not stalled, index arithmetic, output register
  bccng_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .sx             (sx_r),
    .sxy            (sxy_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_nbr_x      (out_nbr_x),
    .out_nbr_y      (out_nbr_y),
    .out_nbr_z      (out_nbr_z),
    .out_site_index (out_site_index),
    .out_none_found (out_none_found),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> rtl/bccng_checker.sv
// ----------------------------------------------------------------------------
// bccng_checker
// port-level checks on the result channel of the neighbor generator
// ----------------------------------------------------------------------------
`default_nettype none

module bccng_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [bccng_pkg::CoordBits-1:0]  out_nbr_x,
  input  wire logic [bccng_pkg::CoordBits-1:0]  out_nbr_y,
  input  wire logic [bccng_pkg::CoordBits-1:0]  out_nbr_z,
  input  wire logic [bccng_pkg::IdxW-1:0]       out_site_index,
  input  wire logic                             out_none_found,
  input  wire logic                             out_last
);
  import bccng_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nbr_x) && $stable(out_nbr_y)
      && $stable(out_nbr_z) && $stable(out_site_index) && $stable(out_none_found)
      && $stable(out_last))
    else $error("result changed while stalled");

  // an empty answer is always the only transfer of its query
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_last)
    else $error("none_found without last");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_nbr_x == '0 && out_nbr_y == '0
      && out_nbr_z == '0 && out_site_index == '0)
    else $error("none_found result carries data");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bcc_lattice_neighbor_generator bccng_checker u_bccng_checker (.*);

`default_nettype wire

>>> dv/bcc_lattice_neighbor_generator_tb.sv
// ----------------------------------------------------------------------------
// bcc_lattice_neighbor_generator_tb
// self-checking bench for the bcc lattice neighbor generator
// ----------------------------------------------------------------------------
// A table of directed queries runs first, under several box sizes: reset
// size, corners and faces, boxes larger than the coordinate range, empty
// boxes and queries outside the box. Rows whose answer is obvious carry it
// inline, the rest go through a local neighbor predictor. Random phases
// follow, each with a fresh box size and mostly in-box queries. Both sides
// idle at random, and twice the receiver holds off long enough to back the
// block up into its query channel. Every result transfer is checked field by
// field against the oldest pending expectation.
// ----------------------------------------------------------------------------

module bcc_lattice_neighbor_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bccng_pkg::*;

  localparam int NumDirRows   = 30;
  localparam int RandPhases   = 8;
  localparam int QueriesPerPh = 29;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 20;
  localparam int LongHold     = 250;
  localparam int CycleLimit   = 500000;
  localparam int MaxPrinted   = 40;

  // one expected or observed result transfer
  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [IdxW-1:0]      index;
    logic                 none_found;
    logic                 last;
  } nbr_result_t;

  // directed table: box rows change the size, query rows send one query
  typedef enum logic [1:0] {
    RowBox,
    RowQuery,
    RowTyped
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [BcxW-1:0]      bcx;
    logic [CfgW-1:0]      bsy;
    logic [CfgW-1:0]      bsz;
    logic                 func;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [CoordBits-1:0] ex;
    logic [CoordBits-1:0] ey;
    logic [CoordBits-1:0] ez;
    logic [IdxW-1:0]      eidx;
    logic                 enone;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgW-1:0]      cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_func;
  logic [CoordBits-1:0] in_site_x;
  logic [CoordBits-1:0] in_site_y;
  logic [CoordBits-1:0] in_site_z;
  logic                 out_valid;
  logic                 out_stall;
  logic [CoordBits-1:0] out_nbr_x;
  logic [CoordBits-1:0] out_nbr_y;
  logic [CoordBits-1:0] out_nbr_z;
  logic [IdxW-1:0]      out_site_index;
  logic                 out_none_found;
  logic                 out_last;

  // predictor's copy of the box size registers, reset value 1
  logic [BcxW-1:0] box_cx = 1;
  logic [CfgW-1:0] box_sy = 1;
  logic [CfgW-1:0] box_sz = 1;

  nbr_result_t nbr_expect_q[$];

  int  err_count     = 0;
  int  queries_sent  = 0;
  int  results_seen  = 0;
  int  empty_results = 0;
  int  box_settings  = 0;
  int  holds_done    = 0;
  int  cycle_count   = 0;
  bit  hold_req      = 1'b0;
  bit  tx_burst      = 1'b0;
  bit  rx_burst      = 1'b0;

  // reset box is 2 x 1 x 1, so the first rows are easy to read off
  stim_row_t dir_rows [NumDirRows] = '{
    '{RowTyped, 0, 0, 0, FuncFirst,  0, 0, 0,          1, 0, 0, 1, 0},
    '{RowTyped, 0, 0, 0, FuncFirst,  1, 0, 0,          0, 0, 0, 0, 0},
    '{RowTyped, 0, 0, 0, FuncSecond, 0, 0, 0,          0, 0, 0, 0, 1},
    '{RowTyped, 0, 0, 0, FuncFirst,  1023, 1023, 1023, 0, 0, 0, 0, 1},
    // small box, faces and corners on both sides
    '{RowBox,   4, 8, 8, FuncFirst,  0, 0, 0,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  3, 3, 3,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  4, 4, 4,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 4, 4, 4,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 0, 0, 0,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  7, 7, 7,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 7, 7, 7,          0, 0, 0, 0, 0},
    '{RowTyped, 0, 0, 0, FuncFirst,  8, 0, 0,          0, 0, 0, 0, 1},
    // register maxima: every size clamps to the coordinate range
    '{RowBox,   1023, 2047, 2047, FuncFirst, 0, 0, 0,  0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  1023, 1023, 1023, 0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 1023, 1023, 1023, 0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  0, 0, 0,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 512, 0, 1023,     0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  682, 341, 682,    0, 0, 0, 0, 0},
    // zero cells along x: empty box
    '{RowBox,   0, 5, 5, FuncFirst,  0, 0, 0,          0, 0, 0, 0, 0},
    '{RowTyped, 0, 0, 0, FuncFirst,  0, 0, 0,          0, 0, 0, 0, 1},
    '{RowTyped, 0, 0, 0, FuncSecond, 2, 2, 2,          0, 0, 0, 0, 1},
    // thin slab, long in y
    '{RowBox,   1, 1024, 1, FuncFirst, 0, 0, 0,        0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 1, 1023, 0,       0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  0, 512, 0,        0, 0, 0, 0, 0},
    // zero sites along z: empty box again
    '{RowBox,   512, 1, 0, FuncFirst, 0, 0, 0,         0, 0, 0, 0, 0},
    '{RowTyped, 0, 0, 0, FuncSecond, 100, 0, 0,        0, 0, 0, 0, 1},
    // tiny box, +x face
    '{RowBox,   2, 2, 2, FuncFirst,  0, 0, 0,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  1, 1, 1,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncFirst,  2, 0, 0,          0, 0, 0, 0, 0},
    '{RowQuery, 0, 0, 0, FuncSecond, 1, 0, 1,          0, 0, 0, 0, 0}
  };

  bcc_lattice_neighbor_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_site_x      (in_site_x),
    .in_site_y      (in_site_y),
    .in_site_z      (in_site_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_nbr_x      (out_nbr_x),
    .out_nbr_y      (out_nbr_y),
    .out_nbr_z      (out_nbr_z),
    .out_site_index (out_site_index),
    .out_none_found (out_none_found),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // box size as used for bounds and index: capped at the coordinate range
  function automatic longint clamp_size(input longint v);
    return (v > (longint'(1) << CoordBits)) ? (longint'(1) << CoordBits) : v;
  endfunction

  // idle length in cycles: mostly none or short, now and then long
  function automatic int idle_len(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // neighbor list for one query under the current box size
  function automatic void predict_neighbors(input logic f, input logic [CoordBits-1:0] qx,
                                            input logic [CoordBits-1:0] qy,
                                            input logic [CoordBits-1:0] qz);
    longint sx, sy, sz, x, y, z, dx, dy, dz, nx, ny, nz, idx;
    logic [CandIdxW-1:0] c;
    int n_cand;
    nbr_result_t found[$];
    nbr_result_t r;
    sx = clamp_size(2 * longint'(box_cx));
    sy = clamp_size(longint'(box_sy));
    sz = clamp_size(longint'(box_sz));
    x = qx;
    y = qy;
    z = qz;
    if (x < sx && y < sy && z < sz) begin
      n_cand = (f == FuncSecond) ? 6 : NumCand;
      for (int i = 0; i < n_cand; i++) begin
        c = i[CandIdxW-1:0];
        dx = 0;
        dy = 0;
        dz = 0;
        if (f == FuncSecond) begin
          case (c)
            SecXMinus: dx = -2;
            SecYMinus: dy = -1;
            SecZMinus: dz = -1;
            SecZPlus:  dz = 1;
            SecYPlus:  dy = 1;
            default:   dx = 2;
          endcase
        end else begin
          // odd x reaches up in y/z, even x reaches down
          dx = MaskXPlus[c] ? 1 : -1;
          dy = (MaskDyHi[c] ? 1 : 0) - (qx[0] ? 0 : 1);
          dz = (MaskDzHi[c] ? 1 : 0) - (qx[0] ? 0 : 1);
        end
        nx = x + dx;
        ny = y + dy;
        nz = z + dz;
        if (nx >= 0 && ny >= 0 && nz >= 0 && nx < sx && ny < sy && nz < sz) begin
          idx = nx + ny * sx + nz * sx * sy;
          r.x = nx[CoordBits-1:0];
          r.y = ny[CoordBits-1:0];
          r.z = nz[CoordBits-1:0];
          r.index = idx[IdxW-1:0];
          r.none_found = 1'b0;
          r.last = 1'b0;
          found.push_back(r);
        end
      end
    end
    // outside the box or nothing inside: a single empty transfer
    if (found.size() == 0) begin
      r = '0;
      r.none_found = 1'b1;
      found.push_back(r);
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[k]) nbr_expect_q.push_back(found[k]);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MaxPrinted) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // box size change: only once the block has drained
  task automatic set_box(input logic [BcxW-1:0] cx, input logic [CfgW-1:0] sy,
                         input logic [CfgW-1:0] sz);
    @(negedge clk);
    in_valid <= 1'b0;
    while (nbr_expect_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= RegBoxCellsX;
    cfg_wdata <= CfgW'(cx);
    @(negedge clk);
    cfg_index <= RegBoxSitesY;
    cfg_wdata <= sy;
    @(negedge clk);
    cfg_index <= RegBoxSitesZ;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we <= 1'b0;
    box_cx = cx;
    box_sy = sy;
    box_sz = sz;
    box_settings++;
  endtask

  // one query transfer; valid stays high afterwards unless the next call idles
  task automatic send_query(input logic f, input logic [CoordBits-1:0] qx,
                            input logic [CoordBits-1:0] qy, input logic [CoordBits-1:0] qz,
                            input bit typed, input nbr_result_t known);
    int gap;
    gap = idle_len(tx_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_site_x <= qx;
    in_site_y <= qy;
    in_site_z <= qz;
    do @(posedge clk); while (in_stall);
    if (typed) nbr_expect_q.push_back(known);
    else predict_neighbors(f, qx, qy, qz);
    queries_sent++;
    // ask the receiver for a long hold-off while queries keep coming
    if (queries_sent == 60 || queries_sent == 180) hold_req = 1'b1;
  endtask

  // coordinate inside a box side, leaning on the two faces; any coordinate for an empty side
  function automatic logic [CoordBits-1:0] pick_coord(input longint side);
    int r;
    r = $urandom_range(0, 99);
    if (side <= 0) return CoordBits'($urandom);
    if (r < 20) return '0;
    if (r < 40) return CoordBits'(side - 1);
    return CoordBits'($urandom_range(0, int'(side - 1)));
  endfunction

  initial begin : stimulus
    nbr_result_t known;
    stim_row_t row;
    int mode;
    logic f;
    logic [CoordBits-1:0] qx, qy, qz;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = RegBoxCellsX;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_func   = FuncFirst;
    in_site_x = '0;
    in_site_y = '0;
    in_site_z = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NumDirRows; i++) begin
      row = dir_rows[i];
      if (i % 8 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      known = '0;
      if (row.kind == RowBox) begin
        set_box(row.bcx, row.bsy, row.bsz);
      end else begin
        known.x = row.ex;
        known.y = row.ey;
        known.z = row.ez;
        known.index = row.eidx;
        known.none_found = row.enone;
        known.last = 1'b1;
        send_query(row.func, row.x, row.y, row.z, row.kind == RowTyped, known);
      end
    end

    // random phases, each under a new box size
    known = '0;
    for (int p = 0; p < RandPhases; p++) begin
      mode = (p == 1) ? 6 : (p == 2) ? 9 : $urandom_range(0, 9);
      if (mode < 6) begin
        set_box(BcxW'($urandom_range(1, 6)), CfgW'($urandom_range(1, 12)),
                CfgW'($urandom_range(1, 12)));
      end else if (mode < 8) begin
        set_box(BcxW'($urandom_range(256, 1023)), CfgW'($urandom_range(600, 2047)),
                CfgW'($urandom_range(600, 2047)));
      end else if (mode == 8) begin
        set_box(BcxW'(1), CfgW'($urandom_range(1, 40)), CfgW'(1));
      end else begin
        set_box(BcxW'($urandom_range(0, 1023)), CfgW'($urandom_range(0, 2047)),
                CfgW'($urandom_range(0, 2047)));
      end
      for (int q = 0; q < QueriesPerPh; q++) begin
        if (q % 10 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        f = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) begin
          qx = pick_coord(clamp_size(2 * longint'(box_cx)));
          qy = pick_coord(clamp_size(longint'(box_sy)));
          qz = pick_coord(clamp_size(longint'(box_sz)));
        end else begin
          // anywhere in the coordinate range, mostly outside small boxes
          qx = CoordBits'($urandom);
          qy = CoordBits'($urandom);
          qz = CoordBits'($urandom);
        end
        send_query(f, qx, qy, qz, 1'b0, known);
      end
    end

    // drain, then watch a little longer for stray transfers
    @(negedge clk);
    in_valid <= 1'b0;
    while (nbr_expect_q.size() != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d queries (%0d directed rows) over %0d box sizes",
             queries_sent, NumDirRows, box_settings);
    $display("checked %0d result transfers, %0d empty, %0d long receiver holds",
             results_seen, empty_results, holds_done);
    if (err_count == 0) begin
      $display("bcc_lattice_neighbor_generator_tb: clean");
    end else begin
      $display("bcc_lattice_neighbor_generator_tb: errors");
    end
    $finish;
  end

  // receiver: random stalls, bursts with none, and the long hold-offs
  initial begin : result_stall_drv
    int n;
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        out_stall <= 1'b1;
        held = 0;
        while (held < LongHold) begin
          @(negedge clk);
          held++;
        end
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        n = idle_len(rx_burst);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // result transfers against the oldest expectation
  always @(posedge clk) begin : result_check
    nbr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_none_found) empty_results++;
      if (nbr_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer x=%0d y=%0d z=%0d idx=%0d none=%0d",
                                  out_nbr_x, out_nbr_y, out_nbr_z, out_site_index,
                                  out_none_found));
      end else begin
        want = nbr_expect_q.pop_front();
        check_field("nbr_x", out_nbr_x, want.x);
        check_field("nbr_y", out_nbr_y, want.y);
        check_field("nbr_z", out_nbr_z, want.z);
        check_field("site_index", out_site_index, want.index);
        check_field("none_found", out_none_found, want.none_found);
        check_field("last", out_last, want.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, nbr_expect_q.size());
      $display("bcc_lattice_neighbor_generator_tb: errors");
      $finish;
    end
  end

endmodule
